/* hw/rtl/rau_pkg.sv */
// shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;
    localparam int OP_W  = 16;
    localparam int PW    = 2 * OP_W;
    localparam int NW    = PW + 1;
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 32;
    localparam int CNT_W = $clog2(PW);

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    typedef struct packed {
        logic signed [NW-1:0] num;
        logic signed [PW-1:0] den;
        logic                 num_zero;
        logic                 den_zero;
    } t_item;
endpackage

/* hw/rtl/rau_front.sv */
// front end: accepts a request, cross-multiplies, combines and classifies
// depends on rau_pkg
module rau_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_command,
    input  logic signed [rau_pkg::OP_W-1:0] i_a,
    input  logic signed [rau_pkg::OP_W-1:0] i_b,
    input  logic signed [rau_pkg::OP_W-1:0] i_c,
    input  logic signed [rau_pkg::OP_W-1:0] i_d,
    input  logic                         i_q_full,
    output logic                         o_push,
    output rau_pkg::t_item               o_item
);
    import rau_pkg::*;

    logic                 r_vld, n_vld;
    logic [1:0]           r_cmd;
    logic signed [PW-1:0] r_p1, r_p2, r_pd;
    logic                 accept;
    logic signed [NW-1:0] num;

    assign busy   = r_vld && i_q_full;
    assign accept = start && !busy;
    assign o_push = r_vld && !i_q_full;

    always_comb begin
        n_vld = r_vld;
        if (o_push) begin
            n_vld = 1'b0;
        end
        if (accept) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // three products in parallel; operands picked by command
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_p1  <= (i_command == CMD_MUL) ? PW'(i_a) * PW'(i_c) : PW'(i_a) * PW'(i_d);
            r_p2  <= PW'(i_b) * PW'(i_c);
            r_pd  <= (i_command == CMD_DIV) ? PW'(i_b) * PW'(i_c) : PW'(i_b) * PW'(i_d);
        end
    end

    always_comb begin
        case (r_cmd)
            CMD_ADD: num = NW'(r_p1) + NW'(r_p2);
            CMD_SUB: num = NW'(r_p1) - NW'(r_p2);
            default: num = NW'(r_p1);
        endcase
    end

    assign o_item.num      = num;
    assign o_item.den      = r_pd;
    assign o_item.num_zero = (num == '0);
    assign o_item.den_zero = (r_pd == '0);
endmodule

/* hw/rtl/rau_queue.sv */
// two-entry queue between the front end and the reduction engine
// depends on rau_pkg
module rau_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rau_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output rau_pkg::t_item o_item
);
    import rau_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule

/* hw/rtl/rau_back.sv */
// reduction engine: binary gcd, then two restoring divisions by the gcd
// depends on rau_pkg
module rau_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_empty,
    input  rau_pkg::t_item                        i_item,
    output logic                                  o_pop,
    output logic                                  o_result_valid,
    output logic signed [rau_pkg::RES_NUM_W-1:0] o_result_numerator,
    output logic signed [rau_pkg::RES_DEN_W-1:0] o_result_denominator,
    output logic                                  o_zero_denominator_error
);
    import rau_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GCD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]       r_state;
    logic [PW-1:0]    r_x, r_y, r_g, r_qn, r_qd;
    logic [PW-1:0]    r_rn, r_rd;
    logic [PW-1:0]    r_nmag, r_dmag;
    logic [CNT_W-1:0] r_k, r_cnt;
    logic             r_nneg, r_dneg;

    logic [PW-1:0]    nmag_w;
    logic [PW-1:0]    dmag_w;
    logic [PW:0]      rn_sh, rd_sh, rn_sub, rd_sub;
    logic [PW-1:0]    qn_next, qd_next;
    logic signed [NW-1:0] num_out;
    logic signed [PW-1:0] den_out;

    assign o_pop  = (r_state == ST_IDLE) && !i_empty;
    assign nmag_w = i_item.num[NW-1] ? PW'(-i_item.num) : PW'(i_item.num);
    assign dmag_w = i_item.den[PW-1] ? PW'(-i_item.den) : PW'(i_item.den);

    // one restoring step per cycle for both quotients
    assign rn_sh  = {r_rn, r_qn[PW-1]};
    assign rd_sh  = {r_rd, r_qd[PW-1]};
    assign rn_sub = rn_sh - {1'b0, r_g};
    assign rd_sub = rd_sh - {1'b0, r_g};
    assign qn_next = {r_qn[PW-2:0], !rn_sub[PW]};
    assign qd_next = {r_qd[PW-2:0], !rd_sub[PW]};
    assign num_out = r_nneg ? -$signed({1'b0, qn_next}) : $signed({1'b0, qn_next});
    assign den_out = r_dneg ? PW'(-qd_next) : PW'(qd_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_item.den_zero || i_item.num_zero) begin
                            o_result_valid <= 1'b1;
                        end else begin
                            r_state <= ST_GCD;
                        end
                    end
                end
                ST_GCD: begin
                    if (r_x == r_y) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == CNT_W'(PW - 1)) begin
                        r_state        <= ST_IDLE;
                        o_result_valid <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x    <= nmag_w;
                r_y    <= dmag_w;
                r_nmag <= nmag_w;
                r_dmag <= dmag_w;
                r_k    <= '0;
                r_nneg <= i_item.num[NW-1];
                r_dneg <= i_item.den[PW-1];
                o_result_numerator       <= '0;
                o_result_denominator     <= i_item.den_zero ? '0 : RES_DEN_W'(1);
                o_zero_denominator_error <= i_item.den_zero;
            end
            ST_GCD: begin
                if (r_x == r_y) begin
                    r_g   <= r_x << r_k;
                    r_qn  <= r_nmag;
                    r_qd  <= r_dmag;
                    r_rn  <= '0;
                    r_rd  <= '0;
                    r_cnt <= '0;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x > r_y) begin
                    r_x <= (r_x - r_y) >> 1;
                end else begin
                    r_y <= (r_y - r_x) >> 1;
                end
            end
            ST_DIV: begin
                r_rn  <= rn_sub[PW] ? rn_sh[PW-1:0] : rn_sub[PW-1:0];
                r_rd  <= rd_sub[PW] ? rd_sh[PW-1:0] : rd_sub[PW-1:0];
                r_qn  <= qn_next;
                r_qd  <= qd_next;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PW - 1)) begin
                    o_result_numerator       <= RES_NUM_W'(num_out);
                    o_result_denominator     <= RES_DEN_W'(den_out);
                    o_zero_denominator_error <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_zero_denominator_error |->
            o_result_numerator == '0 && o_result_denominator == '0)
        else $error("error result not zero");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_zero_denominator_error |-> o_result_denominator != '0)
        else $error("zero denominator without error");
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_GCD |-> r_x != '0 && r_y != '0)
        else $error("gcd operand reached zero");
endmodule

/* hw/rtl/rational_arithmetic_unit_core.sv */
// rational arithmetic unit: one request in, one reduced fraction out
// a zero numerator or denominator skips the gcd loop and the division
// throughput: one request per cycle for zero cases while busy is low; otherwise each request
// waits for the binary gcd loop (one step a cycle) and the 32-step restoring division
// a two-entry queue lets the front end take requests while the back end works
// synchronous active-low reset clears all control state; results cannot be stalled
module rational_arithmetic_unit_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_command,
    input  logic signed [rau_pkg::OP_W-1:0]       i_first_numerator,
    input  logic signed [rau_pkg::OP_W-1:0]       i_first_denominator,
    input  logic signed [rau_pkg::OP_W-1:0]       i_second_numerator,
    input  logic signed [rau_pkg::OP_W-1:0]       i_second_denominator,
    output logic                                  o_result_valid,
    output logic signed [rau_pkg::RES_NUM_W-1:0] o_result_numerator,
    output logic signed [rau_pkg::RES_DEN_W-1:0] o_result_denominator,
    output logic                                  o_zero_denominator_error
);
    import rau_pkg::*;

    t_item f_item, q_item;
    logic  push, pop, q_full, q_empty;

    rau_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_command(i_command),
        .i_a      (i_first_numerator),
        .i_b      (i_first_denominator),
        .i_c      (i_second_numerator),
        .i_d      (i_second_denominator),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (f_item)
    );

    rau_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (f_item),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_item (q_item)
    );

    rau_back u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_empty                 (q_empty),
        .i_item                  (q_item),
        .o_pop                   (pop),
        .o_result_valid          (o_result_valid),
        .o_result_numerator      (o_result_numerator),
        .o_result_denominator    (o_result_denominator),
        .o_zero_denominator_error(o_zero_denominator_error)
    );
endmodule
